### hw/rtl/st2110_video_depacketizer_assert.svh
// assertion macros used by the depacketizer checker
`ifndef ST2110_VIDEO_DEPACKETIZER_ASSERT_SVH
`define ST2110_VIDEO_DEPACKETIZER_ASSERT_SVH

// condition implies consequence in the same cycle
`define ST2110VD_ASSERT_SAME(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define ST2110VD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/st2110vd_pkg.sv
// types and constants of the video depacketizer
`default_nettype none
package st2110vd_pkg;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_FRAME  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       start_of_packet;
    logic       end_of_packet;
    logic       marker;
    logic       header_extension;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } out_item_t;

  // results of one byte before color conversion
  typedef struct packed {
    logic        has_pix;
    logic        has_tail;
    logic [1:0]  tail_kind;
    logic [15:0] row;
    logic [15:0] col0;
    logic [9:0]  cb;
    logic [9:0]  y0;
    logic [9:0]  cr;
    logic [9:0]  y1;
  } raw_bundle_t;

  // results of one byte after color conversion
  typedef struct packed {
    logic        has_pix;
    logic        has_tail;
    logic [1:0]  tail_kind;
    logic [15:0] row;
    logic [15:0] col0;
    logic [15:0] col1;
    logic [7:0]  r0;
    logic [7:0]  g0;
    logic [7:0]  b0;
    logic [7:0]  r1;
    logic [7:0]  g1;
    logic [7:0]  b1;
  } res_bundle_t;

endpackage
`default_nettype wire

### hw/rtl/st2110_video_depacketizer.sv
// ST 2110-20 depacketizer, 4:2:2 10-bit ycbcr pgroups to 8-bit rgb pixels
//
// in_*: one RTP payload byte per request with packet start/end flags and
//   the packet's marker and extension bits; valid/ready handshake.
// out_*: results (pixel, frame complete, packet rejected); last marks the
//   final result caused by one byte. A byte yields zero to three results.
// cfg_*: write of the interlaced bit, taken in the cycle of cfg_wr_en; it
//   also reloads the field countdown. Write it only while idle.
// The first result of a byte passes the parser, the color stage register
//   and the result register before it is shown on out_*.
// Throughput: one byte per cycle. The result register hands out one result
//   a cycle and the color stage holds one more byte's bundle, so the input
//   stalls only when result bytes arrive faster than their results drain.
// Reset clears the parse state, stops collection until the first marked
//   packet ends unrejected, and empties the pipeline. A stalled receiver
//   backs up through the result register and color stage to in_ready.
`default_nettype none
module st2110_video_depacketizer #(
  parameter int MAX_SEGMENTS = 3
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic                     cfg_wr_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire st2110vd_pkg::in_item_t   in_data,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output st2110vd_pkg::out_item_t       out_data
);

  logic                      fire;
  logic                      produce;
  logic                      res_valid;
  logic                      res_ready;
  st2110vd_pkg::raw_bundle_t raw;
  st2110vd_pkg::res_bundle_t res;

  assign fire = in_valid && in_ready;

  // byte parser
  st2110vd_parser #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fire       (fire),
    .item       (in_data),
    .produce    (produce),
    .bundle     (raw)
  );

  // color conversion stage
  st2110vd_color u_color (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (produce),
    .raw      (raw),
    .ready    (in_ready),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // result serializer
  st2110vd_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/st2110vd_parser.sv
// packet parser: sequence number, row headers, pgroup assembly, frame counting
`default_nettype none
module st2110vd_parser #(
  parameter int MAX_SEGMENTS = 3
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  input  wire logic                      fire,
  input  wire st2110vd_pkg::in_item_t    item,
  output logic                           produce,
  output st2110vd_pkg::raw_bundle_t      bundle
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  typedef enum logic [1:0] {PH_SEQ, PH_HDR, PH_DATA, PH_IDLE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        interlaced_r, interlaced_nxt;
  logic        collecting_r, collecting_nxt;
  logic [1:0]  fields_left_r, fields_left_nxt;
  logic [15:0] byte_cnt_r, byte_cnt_nxt;
  logic [2:0]  grp_cnt_r, grp_cnt_nxt;
  logic [1:0]  seg_count_r, seg_count_nxt;
  logic [1:0]  seg_index_r, seg_index_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [15:0] col_r, col_nxt;
  logic        err_r, err_nxt;
  logic        more_r, more_nxt;
  logic [15:0] seg_len_r [MAX_SEGMENTS];
  logic [14:0] seg_row_r [MAX_SEGMENTS];
  logic [14:0] seg_off_r [MAX_SEGMENTS];
  logic [15:0] seg_len_nxt [MAX_SEGMENTS];
  logic [14:0] seg_row_nxt [MAX_SEGMENTS];
  logic [14:0] seg_off_nxt [MAX_SEGMENTS];

  // next-state logic for one accepted byte
  always_comb begin
    logic [7:0]  v;
    logic        do_start;
    logic [1:0]  start_from;
    logic        found;
    logic [1:0]  k;
    logic [14:0] r15;
    logic [39:0] grp;
    phase_nxt       = phase_r;
    interlaced_nxt  = interlaced_r;
    collecting_nxt  = collecting_r;
    fields_left_nxt = fields_left_r;
    byte_cnt_nxt    = byte_cnt_r;
    grp_cnt_nxt     = grp_cnt_r;
    seg_count_nxt   = seg_count_r;
    seg_index_nxt   = seg_index_r;
    shift_nxt       = shift_r;
    col_nxt         = col_r;
    err_nxt         = err_r;
    more_nxt        = more_r;
    seg_len_nxt     = seg_len_r;
    seg_row_nxt     = seg_row_r;
    seg_off_nxt     = seg_off_r;
    bundle          = '0;
    v          = item.payload_byte;
    do_start   = 1'b0;
    start_from = 2'd0;
    found      = 1'b0;
    k          = seg_count_r;
    r15        = '0;
    grp        = '0;

    // packet start clears parse state
    if (item.start_of_packet) begin
      phase_nxt     = PH_SEQ;
      byte_cnt_nxt  = '0;
      seg_count_nxt = '0;
      seg_index_nxt = '0;
      shift_nxt     = '0;
      err_nxt       = 1'b0;
      more_nxt      = 1'b0;
    end
    if (item.header_extension) begin
      err_nxt = 1'b1;
    end

    if (collecting_r && !err_nxt) begin
      k = seg_count_nxt;
      case (phase_nxt)
        PH_SEQ: begin
          byte_cnt_nxt = byte_cnt_nxt + 16'd1;
          if (byte_cnt_nxt >= 16'd2) begin
            phase_nxt    = PH_HDR;
            byte_cnt_nxt = '0;
          end
        end
        PH_HDR: begin
          if (32'(k) >= MAX_SEGMENTS) begin
            err_nxt = 1'b1;
          end else begin
            case (byte_cnt_nxt[2:0])
              3'd0: seg_len_nxt[k[IDX_W-1:0]][15:8] = v;
              3'd1: seg_len_nxt[k[IDX_W-1:0]][7:0]  = v;
              3'd2: seg_row_nxt[k[IDX_W-1:0]][14:8] = v[6:0];
              3'd3: seg_row_nxt[k[IDX_W-1:0]][7:0]  = v;
              3'd4: begin
                seg_off_nxt[k[IDX_W-1:0]][14:8] = v[6:0];
                more_nxt = v[7];
              end
              default: seg_off_nxt[k[IDX_W-1:0]][7:0] = v;
            endcase
            byte_cnt_nxt = byte_cnt_nxt + 16'd1;
            if (byte_cnt_nxt == 16'd6) begin
              seg_count_nxt = k + 2'd1;
              byte_cnt_nxt  = '0;
              if (more_nxt) begin
                if (32'(seg_count_nxt) >= MAX_SEGMENTS) begin
                  err_nxt = 1'b1;
                end
              end else begin
                do_start   = 1'b1;
                start_from = 2'd0;
              end
            end
          end
        end
        PH_DATA: begin
          if (seg_index_nxt >= seg_count_nxt) begin
            phase_nxt = PH_IDLE;
          end else begin
            grp          = {shift_nxt, v};
            shift_nxt    = grp[31:0];
            byte_cnt_nxt = byte_cnt_nxt + 16'd1;
            if (grp_cnt_nxt == 3'd4) begin
              grp_cnt_nxt = '0;
              r15 = seg_row_nxt[seg_index_nxt[IDX_W-1:0]];
              bundle.has_pix = 1'b1;
              bundle.row     = {1'b0, r15};
              if (interlaced_r) begin
                if (fields_left_r == 2'd2) begin
                  bundle.row = {r15, 1'b0};
                end else if (fields_left_r == 2'd1) begin
                  bundle.row = {r15, 1'b1};
                end
              end
              bundle.col0 = col_nxt;
              bundle.cb   = grp[39:30];
              bundle.y0   = grp[29:20];
              bundle.cr   = grp[19:10];
              bundle.y1   = grp[9:0];
              col_nxt     = col_nxt + 16'd2;
            end else begin
              grp_cnt_nxt = grp_cnt_nxt + 3'd1;
            end
            if (byte_cnt_nxt >= seg_len_nxt[seg_index_nxt[IDX_W-1:0]]) begin
              do_start   = 1'b1;
              start_from = seg_index_nxt + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // start the next nonempty segment
    if (do_start) begin
      phase_nxt     = PH_IDLE;
      seg_index_nxt = seg_count_nxt;
      for (int j = 0; j < MAX_SEGMENTS; j++) begin
        if (!found && 2'(j) >= start_from && 2'(j) < seg_count_nxt &&
            seg_len_nxt[j] != 16'd0) begin
          found         = 1'b1;
          phase_nxt     = PH_DATA;
          seg_index_nxt = 2'(j);
          byte_cnt_nxt  = '0;
          grp_cnt_nxt   = '0;
          shift_nxt     = '0;
          col_nxt       = {1'b0, seg_off_nxt[j]};
        end
      end
    end

    // end of packet: reject or count marker
    if (item.end_of_packet) begin
      if (err_nxt) begin
        bundle.has_tail  = 1'b1;
        bundle.tail_kind = st2110vd_pkg::KIND_REJECT;
      end else if (item.marker) begin
        if (collecting_r) begin
          if (fields_left_nxt != 2'd0) begin
            fields_left_nxt = fields_left_nxt - 2'd1;
          end
          if (fields_left_nxt == 2'd0) begin
            bundle.has_tail  = 1'b1;
            bundle.tail_kind = st2110vd_pkg::KIND_FRAME;
            fields_left_nxt  = interlaced_r ? 2'd2 : 2'd1;
          end
        end
        collecting_nxt = 1'b1;
      end
      phase_nxt = PH_IDLE;
    end
  end

  assign produce = fire && (bundle.has_pix || bundle.has_tail);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEQ;
      interlaced_r  <= 1'b0;
      collecting_r  <= 1'b0;
      fields_left_r <= 2'd1;
      byte_cnt_r    <= '0;
      grp_cnt_r     <= '0;
      seg_count_r   <= '0;
      seg_index_r   <= '0;
      shift_r       <= '0;
      col_r         <= '0;
      err_r         <= 1'b0;
      more_r        <= 1'b0;
    end else if (cfg_wr_en) begin
      interlaced_r  <= cfg_wr_data;
      fields_left_r <= cfg_wr_data ? 2'd2 : 2'd1;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      collecting_r  <= collecting_nxt;
      fields_left_r <= fields_left_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
      grp_cnt_r     <= grp_cnt_nxt;
      seg_count_r   <= seg_count_nxt;
      seg_index_r   <= seg_index_nxt;
      shift_r       <= shift_nxt;
      col_r         <= col_nxt;
      err_r         <= err_nxt;
      more_r        <= more_nxt;
    end
    if (fire) begin
      seg_len_r <= seg_len_nxt;
      seg_row_r <= seg_row_nxt;
      seg_off_r <= seg_off_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/st2110vd_color.sv
// input stage register and ycbcr to rgb conversion of both pixels
`default_nettype none
module st2110vd_color (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire st2110vd_pkg::raw_bundle_t   raw,
  output logic                             ready,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output st2110vd_pkg::res_bundle_t        res
);

  logic                      b1_valid_r;
  st2110vd_pkg::raw_bundle_t b1_r;

  // q12 sum scaled down by 16384 and clamped
  function automatic logic [7:0] to8(input logic signed [25:0] q);
    logic [11:0] s;
    s = q[25:14];
    if (q[25]) begin
      to8 = 8'd0;
    end else if (s > 12'd255) begin
      to8 = 8'd255;
    end else begin
      to8 = s[7:0];
    end
  endfunction

  function automatic logic [23:0] conv(input logic [9:0] y, input logic [9:0] cb,
                                       input logic [9:0] cr);
    logic signed [25:0] yd, cbd, crd, r, g, b;
    yd  = $signed({16'd0, y})  - 26'sd64;
    cbd = $signed({16'd0, cb}) - 26'sd512;
    crd = $signed({16'd0, cr}) - 26'sd512;
    r = 26'sd4768 * yd + 26'sd7344 * crd;
    g = 26'sd4768 * yd - 26'sd2187 * crd - 26'sd872 * cbd;
    b = 26'sd4768 * yd + 26'sd8663 * cbd;
    conv = {to8(r), to8(g), to8(b)};
  endfunction

  assign ready     = !b1_valid_r || res_ready;
  assign res_valid = b1_valid_r;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (ready) begin
      b1_valid_r <= load;
    end
    if (ready && load) begin
      b1_r <= raw;
    end
  end

  // color math on the registered bundle
  always_comb begin
    logic [23:0] p0, p1;
    p0 = conv(b1_r.y0, b1_r.cb, b1_r.cr);
    p1 = conv(b1_r.y1, b1_r.cb, b1_r.cr);
    res.has_pix   = b1_r.has_pix;
    res.has_tail  = b1_r.has_tail;
    res.tail_kind = b1_r.tail_kind;
    res.row       = b1_r.row;
    res.col0      = b1_r.col0;
    res.col1      = b1_r.col0 + 16'd1;
    res.r0 = p0[23:16];
    res.g0 = p0[15:8];
    res.b0 = p0[7:0];
    res.r1 = p1[23:16];
    res.g1 = p1[15:8];
    res.b1 = p1[7:0];
  end

endmodule
`default_nettype wire

### hw/rtl/st2110vd_serial.sv
// result register that hands out up to three results of one byte in order
`default_nettype none
module st2110vd_serial (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        res_valid,
  output logic                             res_ready,
  input  wire st2110vd_pkg::res_bundle_t   res,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output st2110vd_pkg::out_item_t          out_data
);

  logic                      valid_r;
  logic [1:0]                idx_r;
  st2110vd_pkg::res_bundle_t held_r;
  logic                      at_last;

  // last result of the held bundle
  always_comb begin
    if (held_r.has_pix) begin
      at_last = held_r.has_tail ? (idx_r == 2'd2) : (idx_r == 2'd1);
    end else begin
      at_last = 1'b1;
    end
  end

  assign res_ready = !valid_r || (out_ready && at_last);
  assign out_valid = valid_r;

  // select current result
  always_comb begin
    out_data      = '0;
    out_data.last = at_last;
    if (held_r.has_pix && idx_r == 2'd0) begin
      out_data.kind   = st2110vd_pkg::KIND_PIXEL;
      out_data.row    = held_r.row;
      out_data.column = held_r.col0;
      out_data.red    = held_r.r0;
      out_data.green  = held_r.g0;
      out_data.blue   = held_r.b0;
    end else if (held_r.has_pix && idx_r == 2'd1) begin
      out_data.kind   = st2110vd_pkg::KIND_PIXEL;
      out_data.row    = held_r.row;
      out_data.column = held_r.col1;
      out_data.red    = held_r.r1;
      out_data.green  = held_r.g1;
      out_data.blue   = held_r.b1;
    end else begin
      out_data.kind = held_r.tail_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (res_ready) begin
      valid_r <= res_valid;
      idx_r   <= '0;
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
    if (res_ready && res_valid) begin
      held_r <= res;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/st2110vd_checker.sv
// port-level checks of the depacketizer and their bind
`default_nettype none
`include "st2110_video_depacketizer_assert.svh"
module st2110vd_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire st2110vd_pkg::out_item_t  out_data
);

  `ST2110VD_ASSERT_SAME(a_kind_legal, clk, rst_n, out_valid, out_data.kind <= st2110vd_pkg::KIND_REJECT, "bad kind")
  `ST2110VD_ASSERT_SAME(a_tail_last, clk, rst_n, out_valid && out_data.kind != st2110vd_pkg::KIND_PIXEL, out_data.last, "tail not last")
  `ST2110VD_ASSERT_SAME(a_tail_zero, clk, rst_n, out_valid && out_data.kind != st2110vd_pkg::KIND_PIXEL, out_data.row == 16'd0 && out_data.column == 16'd0 && out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0, "tail payload not zero")
  `ST2110VD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `ST2110VD_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid, "request dropped before accept")

endmodule

bind st2110_video_depacketizer st2110vd_checker u_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
`default_nettype wire

### test/tb_st2110_video_depacketizer.sv
// self-checking testbench for the st2110 video depacketizer
`default_nettype none
module tb_st2110_video_depacketizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SEG = 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] PH_SEQ = 2'd0, PH_HDR = 2'd1, PH_DATA = 2'd2, PH_IDLE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  st2110vd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  st2110vd_pkg::out_item_t out_data;

  always #10 clk = ~clk;

  st2110_video_depacketizer #(.MAX_SEGMENTS(MAX_SEG)) DUT (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  logic        p_interlaced;
  logic        p_collecting;
  logic [1:0]  p_fields_left;
  logic [1:0]  p_phase;
  logic [15:0] p_bytes;
  logic [1:0]  p_seg_count;
  logic [1:0]  p_seg_idx;
  logic [15:0] p_len [MAX_SEG];
  logic [14:0] p_row [MAX_SEG];
  logic [14:0] p_off [MAX_SEG];
  logic [39:0] p_group;
  logic [15:0] p_col;
  logic        p_error;
  logic        p_more;

  st2110vd_pkg::out_item_t expected_results[$];
  st2110vd_pkg::out_item_t step_results[$];

  int mismatches = 0;
  int pixels_seen = 0;
  int frames_seen = 0;
  int rejects_seen = 0;
  int bytes_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit receiver_hold = 1'b0;
  int quiet_cycles = 0;

  function automatic logic [7:0] clamp8(int q);
    if (q < 0) return 8'd0;
    q = q >>> 14;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  task automatic push_result(logic [1:0] k, logic [15:0] r, logic [15:0] c,
                             logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    st2110vd_pkg::out_item_t o;
    o.kind = k; o.row = r; o.column = c;
    o.red = rd; o.green = gr; o.blue = bl; o.last = 1'b0;
    step_results.push_back(o);
  endtask

  task automatic reset_predictor();
    p_interlaced = 1'b0; p_collecting = 1'b0; p_fields_left = 2'd1; p_phase = PH_SEQ;
    p_bytes = '0; p_seg_count = '0; p_seg_idx = '0; p_group = '0; p_col = '0;
    p_error = 1'b0; p_more = 1'b0;
    for (int i = 0; i < MAX_SEG; i++) begin
      p_len[i] = '0; p_row[i] = '0; p_off[i] = '0;
    end
  endtask

  // advance to the next nonempty segment or go idle
  task automatic next_segment();
    while (p_seg_idx < p_seg_count && p_len[p_seg_idx] == 0) p_seg_idx++;
    if (p_seg_idx >= p_seg_count) begin
      p_phase = PH_IDLE;
    end else begin
      p_phase = PH_DATA; p_bytes = '0; p_group = '0; p_col = {1'b0, p_off[p_seg_idx]};
    end
  endtask

  task automatic color_pixel(logic [9:0] y, logic [9:0] cb, logic [9:0] cr);
    int yd, cbd, crd;
    logic [15:0] r;
    yd = int'(y) - 64; cbd = int'(cb) - 512; crd = int'(cr) - 512;
    r = {1'b0, p_row[p_seg_idx]};
    if (p_interlaced) begin
      if (p_fields_left == 2) r = r << 1;
      else if (p_fields_left == 1) r = (r << 1) + 16'd1;
    end
    push_result(st2110vd_pkg::KIND_PIXEL, r, p_col, clamp8(4768 * yd + 7344 * crd),
                clamp8(4768 * yd - 2187 * crd - 872 * cbd), clamp8(4768 * yd + 8663 * cbd));
    p_col = p_col + 16'd1;
  endtask

  task automatic parse_byte(logic [7:0] v);
    int k;
    k = int'(p_seg_count);
    case (p_phase)
      PH_SEQ: begin
        p_bytes++;
        if (p_bytes >= 2) begin
          p_phase = PH_HDR; p_bytes = '0;
        end
      end
      PH_HDR: begin
        if (k >= MAX_SEG) begin
          p_error = 1'b1;
        end else begin
          case (p_bytes)
            0: p_len[k] = {v, 8'd0};
            1: p_len[k][7:0] = v;
            2: p_row[k] = {v[6:0], 8'd0};
            3: p_row[k][7:0] = v;
            4: begin
              p_off[k] = {v[6:0], 8'd0}; p_more = v[7];
            end
            default: p_off[k][7:0] = v;
          endcase
          p_bytes++;
          if (p_bytes == 6) begin
            p_seg_count = 2'(k + 1); p_bytes = '0;
            if (p_more) begin
              if (p_seg_count >= MAX_SEG) p_error = 1'b1;
            end else begin
              p_seg_idx = '0; next_segment();
            end
          end
        end
      end
      PH_DATA: begin
        if (p_seg_idx >= p_seg_count) begin
          p_phase = PH_IDLE;
        end else begin
          p_group = {p_group[31:0], v};
          p_bytes++;
          if (p_bytes % 5 == 0) begin
            color_pixel(p_group[29:20], p_group[39:30], p_group[19:10]);
            color_pixel(p_group[9:0], p_group[39:30], p_group[19:10]);
          end
          if (p_bytes >= p_len[p_seg_idx]) begin
            p_seg_idx++; next_segment();
          end
        end
      end
      default: ;
    endcase
  endtask

  // expected results of one accepted request
  task automatic predict_depacketize(st2110vd_pkg::in_item_t it);
    step_results.delete();
    if (it.start_of_packet) begin
      p_phase = PH_SEQ; p_bytes = '0; p_seg_count = '0; p_seg_idx = '0;
      p_group = '0; p_error = 1'b0; p_more = 1'b0;
    end
    if (it.header_extension) p_error = 1'b1;
    if (p_collecting && !p_error) parse_byte(it.payload_byte);
    if (it.end_of_packet) begin
      if (p_error) begin
        push_result(st2110vd_pkg::KIND_REJECT, '0, '0, '0, '0, '0);
      end else if (it.marker) begin
        if (p_collecting) begin
          if (p_fields_left > 0) p_fields_left--;
          if (p_fields_left == 0) begin
            push_result(st2110vd_pkg::KIND_FRAME, '0, '0, '0, '0, '0);
            p_fields_left = p_interlaced ? 2'd2 : 2'd1;
          end
        end
        p_collecting = 1'b1;
      end
      p_phase = PH_IDLE;
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // send one request and wait for acceptance; valid stays up for a following request
  task automatic send_byte(st2110vd_pkg::in_item_t it);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_depacketize(it);
    bytes_sent++;
  endtask

  function automatic st2110vd_pkg::in_item_t mk_item(logic [7:0] b, bit sop, bit eop, bit mk,
                                                     bit ext);
    st2110vd_pkg::in_item_t it;
    it.payload_byte = b; it.start_of_packet = sop; it.end_of_packet = eop;
    it.marker = mk; it.header_extension = ext;
    return it;
  endfunction

  // packet from a byte list
  task automatic send_packet(logic [7:0] bytes[$], bit mk, bit ext);
    for (int i = 0; i < bytes.size(); i++)
      send_byte(mk_item(bytes[i], i == 0, i == bytes.size() - 1, mk, ext));
  endtask

  // build a packet with nseg segment headers and random payload; ext sets the extension bit, trunc cuts it short
  task automatic random_packet(int nseg, bit mk, bit ext, bit trunc);
    logic [7:0] b[$];
    int lens[3];
    int cut;
    b.push_back(8'($urandom)); b.push_back(8'($urandom));
    for (int s = 0; s < nseg; s++) begin
      lens[s] = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3) * 5 + $urandom_range(9) / 7;
      if ($urandom_range(19) == 0) lens[s] = $urandom_range(1, 4);
      b.push_back(8'(lens[s] >> 8)); b.push_back(8'(lens[s]));
      b.push_back(8'($urandom)); b.push_back(8'($urandom));
      b.push_back({(s != nseg - 1) ? 1'b1 : 1'b0, 7'($urandom)});
      b.push_back(8'($urandom));
    end
    for (int s = 0; s < nseg; s++)
      for (int j = 0; j < lens[s]; j++) b.push_back(8'($urandom));
    if ($urandom_range(3) == 0) b.push_back(8'($urandom));
    if (trunc && b.size() > 3) begin
      cut = $urandom_range(1, b.size() - 1);
      while (b.size() > cut) void'(b.pop_back());
    end
    send_packet(b, mk, ext);
  endtask

  // drop valid, wait until every expected result arrived, then pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_interlaced(bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_interlaced = v;
    p_fields_left = v ? 2'd2 : 2'd1;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      quiet_cycles <= 0;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        st2110vd_pkg::out_item_t e;
        e = expected_results.pop_front();
        if (out_data !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
        case (out_data.kind)
          st2110vd_pkg::KIND_PIXEL: pixels_seen++;
          st2110vd_pkg::KIND_FRAME: frames_seen++;
          default: rejects_seen++;
        endcase
      end
    end else if (rst_n && in_valid && in_ready) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (receiver_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // directed rows: byte, sop, eop, marker, ext
  typedef struct {
    logic [7:0] b;
    bit sop, eop, mk, ext;
  } row_t;

  row_t directed[$];

  task automatic add_row(logic [7:0] b, bit sop, bit eop, bit mk, bit ext);
    row_t r;
    r.b = b; r.sop = sop; r.eop = eop; r.mk = mk; r.ext = ext;
    directed.push_back(r);
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejected packet before collection, marker packet, two extreme pgroups
    add_row(8'hFF, 1, 1, 1, 1);                            // rejected single byte
    add_row(8'h00, 1, 0, 1, 0); add_row(8'hFF, 0, 1, 1, 0); // opens collection
    add_row(8'h12, 1, 0, 0, 0); add_row(8'h34, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 0); add_row(8'h0A, 0, 0, 0, 0); // length 10
    add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0); // row 7fff
    add_row(8'h7F, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0); // offset 7fff
    add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0); // all-zero pgroup
    add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0); add_row(8'h00, 0, 0, 0, 0);
    add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0); // all-ones pgroup
    add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 0, 0); add_row(8'hFF, 0, 0, 1, 0);
    add_row(8'h55, 0, 0, 0, 0);                             // ignored after end
    add_row(8'h00, 1, 1, 1, 0);                             // frame complete
    foreach (directed[i])
      send_byte(mk_item(directed[i].b, directed[i].sop, directed[i].eop,
                        directed[i].mk, directed[i].ext));
    wait_idle();

    // three idling phases, each with both interlace settings
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 61 : 0;
      receiver_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 16 : 0;
      for (int cfg = 0; cfg < 2; cfg++) begin
        write_interlaced(cfg[0] ^ ph[0]);
        while (bytes_sent < 24 + (ph * 2 + cfg + 1) * 70) begin
          case ($urandom_range(9))
            0: random_packet($urandom_range(1, 3), 1'($urandom_range(1)), 1, 0);
            1: random_packet(3, 0, 0, 0);
            2: random_packet($urandom_range(1, 3), 1'($urandom_range(1)), 0, 1);
            3: send_byte(mk_item(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 1'($urandom_range(1)), 1'($urandom_range(1))));
            default: random_packet($urandom_range(1, 3), $urandom_range(3) == 0, 0, 0);
          endcase
          if (ph == 2 && cfg == 1 && !receiver_hold && bytes_sent > 384) begin
            fork
              begin
                receiver_hold = 1'b1;
                repeat (300) @(posedge clk);
                receiver_hold = 1'b0;
              end
            join_none
          end
        end
        wait_idle();
      end
    end
    // a burst of noise with all flags, then settle
    sender_idle_pct = 0;
    repeat (12) send_byte(mk_item(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)), 1'($urandom_range(1))));
    wait_idle();
    repeat (20) @(posedge clk);

    $display("sent %0d payload bytes over both interlace settings and three idle mixes",
             bytes_sent);
    $display("checked %0d pixels, %0d frame ends, %0d rejects, %0d errors",
             pixels_seen, frames_seen, rejects_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/st2110vd_pkg.sv
hw/rtl/st2110vd_parser.sv
hw/rtl/st2110vd_color.sv
hw/rtl/st2110vd_serial.sv
hw/rtl/st2110_video_depacketizer.sv
hw/rtl/st2110vd_checker.sv
test/tb_st2110_video_depacketizer.sv
